// File: hdl/rgbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbb_pkg;

	// operation codes
	localparam logic [1:0] OP_COLORIZE = 2'd0;
	localparam logic [1:0] OP_MODULATE = 2'd1;
	localparam logic [1:0] OP_BLEND    = 2'd2;
	localparam logic [1:0] OP_COMPOSE  = 2'd3;

	// register indexes
	localparam logic REG_DARK  = 1'b0;
	localparam logic REG_LIGHT = 1'b1;

	localparam logic [23:0] DARK_RESET  = 24'h000000;
	localparam logic [23:0] LIGHT_RESET = 24'hFFFFFF;
	localparam logic [7:0]  MID_GRAY    = 8'd128;

	// one channel interpolation request: c1 + (x * (c2 - c1)) / 255
	typedef struct packed {
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] x;
	} lerp_req_t;

endpackage

`default_nettype wire

// File: hdl/rgbb_lerp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbb_lerp_lane (
	input  wire logic              clk,
	input  wire rgbb_pkg::lerp_req_t req,
	output logic [7:0]             chan
);

	logic [7:0]  abs_diff;
	logic        neg;
	logic [15:0] mag_s2;
	logic        neg_s2;
	logic [7:0]  c1_s2;
	logic [16:0] q_sum;
	logic [7:0]  quot;
	logic [7:0]  chan_s3;

	// form |c2 - c1| and its sign
	always_comb begin
		neg      = (req.c2 < req.c1);
		abs_diff = neg ? (req.c1 - req.c2) : (req.c2 - req.c1);
	end

	// multiply stage
	always_ff @(posedge clk) begin
		mag_s2 <= 16'(req.x) * 16'(abs_diff);
		neg_s2 <= neg;
		c1_s2  <= req.c1;
	end

	// divide by 255 exactly for values below 65535, truncating toward zero
	always_comb begin
		q_sum = 17'(mag_s2) + 17'(mag_s2[15:8]) + 17'd1;
		quot  = q_sum[15:8];
	end

	// add stage
	always_ff @(posedge clk) begin
		chan_s3 <= neg_s2 ? (c1_s2 - quot) : (c1_s2 + quot);
	end

	assign chan = chan_s3;

endmodule

`default_nettype wire

// File: hdl/rgb_pixel_blend_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel      Signals                                          Direction
// command      start, busy, operation, dest_pixel,              in (busy out)
//              gray_level, fore_pixel
// result       result_valid, result_pixel                       out
// config       cfg_we, cfg_index, cfg_data                      in
//
// One pixel enters every cycle; busy is never raised.
// Each pixel passes through the registered stages in order: select, per-channel multiply, divide-by-255 and add.
// arst_n clears the valid bits and resets the colour registers (dark to black, light to white); payload is not reset.
// The receiver cannot stall, so each result shows for exactly one cycle.

module rgb_pixel_blend_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] dest_pixel,
	input  wire logic [7:0]  gray_level,
	input  wire logic [31:0] fore_pixel,
	output logic             result_valid,
	output logic [31:0]      result_pixel,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [23:0] cfg_data
);

	logic [23:0] dark_q;
	logic [23:0] light_q;

	logic [23:0] c1_sel;
	logic [23:0] c2_sel;
	logic [7:0]  x_sel;
	logic [7:0]  alpha_sel;

	logic [23:0] c1_s1;
	logic [23:0] c2_s1;
	logic [7:0]  x_s1;
	logic [7:0]  alpha_s1;
	logic        valid_s1;
	logic [7:0]  alpha_s2;
	logic        valid_s2;
	logic [7:0]  alpha_s3;
	logic        valid_s3;

	logic [7:0]  chan_r;
	logic [7:0]  chan_g;
	logic [7:0]  chan_b;

	rgbb_pkg::lerp_req_t req_r;
	rgbb_pkg::lerp_req_t req_g;
	rgbb_pkg::lerp_req_t req_b;

	assign busy = 1'b0;

	// colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= rgbb_pkg::DARK_RESET;
			light_q <= rgbb_pkg::LIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbb_pkg::REG_DARK:  dark_q  <= cfg_data;
				rgbb_pkg::REG_LIGHT: light_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pick end points, weight and alpha for the mode
	always_comb begin
		c1_sel    = dest_pixel[23:0];
		c2_sel    = dest_pixel[23:0];
		x_sel     = 8'd0;
		alpha_sel = dest_pixel[31:24];
		case (operation)
			rgbb_pkg::OP_COLORIZE: begin
				// both halves scale the low seven bits by two
				x_sel = {gray_level[6:0], 1'b0};
				if (gray_level >= rgbb_pkg::MID_GRAY) begin
					c2_sel = light_q;
				end else begin
					c1_sel = dark_q;
				end
			end
			rgbb_pkg::OP_MODULATE: begin
				c1_sel = 24'd0;
				x_sel  = gray_level;
			end
			rgbb_pkg::OP_BLEND: begin
				c2_sel = fore_pixel[23:0];
				x_sel  = fore_pixel[31:24];
			end
			rgbb_pkg::OP_COMPOSE: begin
				// zero weight passes the destination colour through
				alpha_sel = gray_level;
			end
			default: ;
		endcase
	end

	// select stage
	always_ff @(posedge clk) begin
		c1_s1    <= c1_sel;
		c2_s1    <= c2_sel;
		x_s1     <= x_sel;
		alpha_s1 <= alpha_sel;
		alpha_s2 <= alpha_s1;
		alpha_s3 <= alpha_s2;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign req_r = '{c1: c1_s1[23:16], c2: c2_s1[23:16], x: x_s1};
	assign req_g = '{c1: c1_s1[15:8],  c2: c2_s1[15:8],  x: x_s1};
	assign req_b = '{c1: c1_s1[7:0],   c2: c2_s1[7:0],   x: x_s1};

	rgbb_lerp_lane u_lane_r (.clk(clk), .req(req_r), .chan(chan_r));
	rgbb_lerp_lane u_lane_g (.clk(clk), .req(req_g), .chan(chan_g));
	rgbb_lerp_lane u_lane_b (.clk(clk), .req(req_b), .chan(chan_b));

	assign result_valid = valid_s3;
	assign result_pixel = {alpha_s3, chan_r, chan_g, chan_b};

`ifndef ASSERT_OFF
	// every accepted beat produces a result once it has passed valid_s1, valid_s2 and valid_s3
	assert property (@(posedge clk) disable iff (!arst_n) start |-> ##3 result_valid)
		else $error("accepted beat did not produce a result");

	// compose writes the gray level into alpha and passes the destination colour through
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && operation == rgbb_pkg::OP_COMPOSE) |-> ##3
		(result_pixel[31:24] == $past(gray_level, 3)
		&& result_pixel[23:0] == $past(dest_pixel[23:0], 3)))
		else $error("compose result wrong");

	// other modes keep the destination alpha
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && operation != rgbb_pkg::OP_COMPOSE) |-> ##3
		(result_pixel[31:24] == $past(dest_pixel[31:24], 3)))
		else $error("destination alpha not kept");
`endif

endmodule

`default_nettype wire
